>>> hdl/bde_pkg.sv
// ----------------------------------------------------------------------------
// bde_pkg
// Shared types and constants of the byte deque engine: request codes, field
// widths and the controller-to-datapath command group.
// ----------------------------------------------------------------------------
package bde_pkg;

  localparam int unsigned BDE_DEPTH = 1024;

  localparam int unsigned REQ_W     = 3;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned POS_W     = 10;
  localparam int unsigned IN_DATA_W = ((BYTE_W + POS_W + 7) / 8) * 8;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_READ       = 3'd4
  } req_e;

  typedef struct packed {
    logic load;  // capture the accepted request
    logic exec;  // run the request against the store and pointers
  } cmd_t;

endpackage

>>> hdl/bde_ram.sv
// ----------------------------------------------------------------------------
// bde_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module bde_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/bde_ctrl.sv
// ----------------------------------------------------------------------------
// bde_ctrl
// Request sequencer: accept a word, run it against the store, then present
// the result until the sink takes it.
// ----------------------------------------------------------------------------
module bde_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output bde_pkg::cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } state_e;

  state_e state_q;
  logic   in_ready_q;
  logic   out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q    <= S_EXEC;
            in_ready_q <= 1'b0;
          end
        end
        S_EXEC: begin
          state_q     <= S_RESP;
          out_valid_q <= 1'b1;
        end
        S_RESP: begin
          if (out_ready_i) begin
            state_q     <= S_IDLE;
            out_valid_q <= 1'b0;
            in_ready_q  <= 1'b1;
          end
        end
        default: begin
          state_q     <= S_IDLE;
          in_ready_q  <= 1'b1;
          out_valid_q <= 1'b0;
        end
      endcase
    end
  end

  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;
  assign cmd_o.load  = in_ready_q & in_valid_i;
  assign cmd_o.exec  = (state_q == S_EXEC);

endmodule

>>> hdl/bde_dpath.sv
// ----------------------------------------------------------------------------
// bde_dpath
// Deque datapath: request registers, head pointer and count, circular slot
// arithmetic and the byte store.
// ----------------------------------------------------------------------------
module bde_dpath #(
  parameter int unsigned Depth = bde_pkg::BDE_DEPTH,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1,
  localparam int unsigned CountW = $clog2(Depth + 1)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  bde_pkg::cmd_t              cmd_i,
  input  logic [bde_pkg::REQ_W-1:0]  req_type_i,
  input  logic [bde_pkg::BYTE_W-1:0] push_byte_i,
  input  logic [bde_pkg::POS_W-1:0]  position_i,
  output logic [bde_pkg::BYTE_W-1:0] data_out_o,
  output logic                       success_o,
  output logic [CountW-1:0]          fill_level_o
);

  localparam int unsigned CmpW = (CountW > bde_pkg::POS_W) ? CountW : bde_pkg::POS_W;
  localparam logic [CountW-1:0] FullCount = CountW'(Depth);
  localparam logic [AddrW-1:0]  LastSlot  = AddrW'(Depth - 1);

  // (a + b) mod Depth for a, b below Depth
  function automatic logic [AddrW-1:0] slot_add(input logic [AddrW-1:0] a,
                                                input logic [AddrW-1:0] b);
    logic [AddrW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (AddrW+1)'(Depth)) begin
      s = s - (AddrW+1)'(Depth);
    end
    return s[AddrW-1:0];
  endfunction

  logic [bde_pkg::REQ_W-1:0]  req_q;
  logic [bde_pkg::BYTE_W-1:0] byte_q;
  logic [bde_pkg::POS_W-1:0]  pos_q;

  logic [AddrW-1:0]  head_q, head_d;
  logic [CountW-1:0] count_q, count_d;
  logic              ok_q, ok_d;
  logic              rd_q, rd_d;

  logic [AddrW-1:0]          offset;
  logic [AddrW-1:0]          ram_addr;
  logic                      ram_en;
  logic                      ram_we;
  logic [bde_pkg::BYTE_W-1:0] ram_rdata;
  logic                      full;
  logic                      empty;
  logic                      in_range;

  assign full     = (count_q == FullCount);
  assign empty    = (count_q == '0);
  assign in_range = (CmpW'(pos_q) < CmpW'(count_q));
  assign ram_addr = slot_add(head_q, offset);

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    ok_d    = ok_q;
    rd_d    = rd_q;
    offset  = '0;
    ram_en  = 1'b0;
    ram_we  = 1'b0;
    if (cmd_i.exec) begin
      ok_d = 1'b0;
      rd_d = 1'b0;
      unique case (req_q)
        bde_pkg::REQ_PUSH_FRONT: begin
          offset = LastSlot;
          if (!full) begin
            ram_en  = 1'b1;
            ram_we  = 1'b1;
            head_d  = slot_add(head_q, LastSlot);
            count_d = count_q + CountW'(1);
            ok_d    = 1'b1;
          end
        end
        bde_pkg::REQ_PUSH_BACK: begin
          offset = AddrW'(count_q);
          if (!full) begin
            ram_en  = 1'b1;
            ram_we  = 1'b1;
            count_d = count_q + CountW'(1);
            ok_d    = 1'b1;
          end
        end
        bde_pkg::REQ_POP_FRONT: begin
          if (!empty) begin
            ram_en  = 1'b1;
            head_d  = slot_add(head_q, AddrW'(1));
            count_d = count_q - CountW'(1);
            ok_d    = 1'b1;
            rd_d    = 1'b1;
          end
        end
        bde_pkg::REQ_POP_BACK: begin
          offset = AddrW'(count_q - CountW'(1));
          if (!empty) begin
            ram_en  = 1'b1;
            count_d = count_q - CountW'(1);
            ok_d    = 1'b1;
            rd_d    = 1'b1;
          end
        end
        bde_pkg::REQ_READ: begin
          offset = AddrW'(pos_q);
          if (in_range) begin
            ram_en = 1'b1;
            ok_d   = 1'b1;
            rd_d   = 1'b1;
          end
        end
        default: begin
          // unknown request: no effect, flag cleared
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q  <= req_type_i;
      byte_q <= push_byte_i;
      pos_q  <= position_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      ok_q    <= 1'b0;
      rd_q    <= 1'b0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      ok_q    <= ok_d;
      rd_q    <= rd_d;
    end
  end

  bde_ram #(
    .Width (bde_pkg::BYTE_W),
    .Depth (Depth)
  ) u_store (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (byte_q),
    .rdata_o (ram_rdata)
  );

  // read data holds until the next store read, which follows the handoff
  assign data_out_o   = rd_q ? ram_rdata : '0;
  assign success_o    = ok_q;
  assign fill_level_o = count_q;

endmodule

>>> hdl/byte_deque_engine_core.sv
// ----------------------------------------------------------------------------
// byte_deque_engine_core
// Double-ended byte queue on a circular store: push/pop at either end and
// read by position from the front; one result word per request.
// ----------------------------------------------------------------------------
//  Channel | Direction | tdata (low bit up)          | tuser
//  s_axis  | in        | push_byte, position         | req_type
//  m_axis  | out       | data_out, fill_level        | success
//
//  A request accepted on s_axis is captured in the request registers; in
//  the EXEC state it does its store access (write, or read with registered
//  data), and the result word is valid from then on until the sink takes
//  it. A new request is taken only after the result word has been taken,
//  so a stall on m_axis holds s_axis_tready low.
//  Reset clears head pointer and count; the store itself is not cleared and
//  there is no clearing pass.
// ----------------------------------------------------------------------------
module byte_deque_engine_core #(
  parameter int unsigned DEPTH = bde_pkg::BDE_DEPTH,
  localparam int unsigned CountW = $clog2(DEPTH + 1),
  localparam int unsigned OutDataW = ((bde_pkg::BYTE_W + CountW + 7) / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [bde_pkg::IN_DATA_W-1:0] s_axis_tdata,  // push_byte, position
  input  logic [bde_pkg::REQ_W-1:0]     s_axis_tuser,  // req_type
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [OutDataW-1:0]           m_axis_tdata,  // data_out, fill_level
  output logic                          m_axis_tuser   // success
);

  localparam int unsigned PadW = OutDataW - bde_pkg::BYTE_W - CountW;

  bde_pkg::cmd_t              cmd;
  logic [bde_pkg::BYTE_W-1:0] data_out;
  logic [CountW-1:0]          fill_level;

  bde_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  bde_dpath #(
    .Depth (DEPTH)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .req_type_i   (s_axis_tuser),
    .push_byte_i  (s_axis_tdata[bde_pkg::BYTE_W-1:0]),
    .position_i   (s_axis_tdata[bde_pkg::BYTE_W +: bde_pkg::POS_W]),
    .data_out_o   (data_out),
    .success_o    (m_axis_tuser),
    .fill_level_o (fill_level)
  );

  generate
    if (PadW > 0) begin : g_pad
      assign m_axis_tdata = {{PadW{1'b0}}, fill_level, data_out};
    end else begin : g_nopad
      assign m_axis_tdata = {fill_level, data_out};
    end
  endgenerate

endmodule

>>> bench/byte_deque_engine_core_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_deque_engine_core_checker
// Watches both stream channels of the byte deque. Every request word taken on
// s_axis runs through a local deque model that yields the expected result
// word. Every result word taken on m_axis is compared field by field with
// the oldest expected word.
// ----------------------------------------------------------------------------
module byte_deque_engine_core_checker #(
  parameter int unsigned OUT_W = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  input  logic [bde_pkg::IN_DATA_W-1:0] s_axis_tdata,   // push_byte, position
  input  logic [bde_pkg::REQ_W-1:0]     s_axis_tuser,   // req_type
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  input  logic [OUT_W-1:0]              m_axis_tdata,   // data_out, fill_level
  input  logic                          m_axis_tuser,   // success
  output int                            fail_count_o,
  output int                            pending_o
);

  localparam int unsigned DEPTH   = bde_pkg::BDE_DEPTH;
  localparam int unsigned COUNT_W = $clog2(DEPTH + 1);
  localparam int unsigned REQ_W   = bde_pkg::REQ_W;
  localparam int unsigned BYTE_W  = bde_pkg::BYTE_W;
  localparam int unsigned POS_W   = bde_pkg::POS_W;

  typedef struct packed {
    logic [BYTE_W-1:0]  data;
    logic               ok;
    logic [COUNT_W-1:0] level;
  } deque_result_t;

  logic [BYTE_W-1:0]  model_store [DEPTH];
  logic [POS_W-1:0]   front_slot;
  logic [COUNT_W-1:0] held;
  deque_result_t      expected_q [$];

  function automatic logic [POS_W-1:0] slot_at(input int offset);
    return POS_W'((int'(front_slot) + offset) % DEPTH);
  endfunction

  // Apply one request to the local deque and return the result it causes.
  function automatic deque_result_t apply_request(
    input logic [REQ_W-1:0]  kind,
    input logic [BYTE_W-1:0] value,
    input logic [POS_W-1:0]  pos
  );
    deque_result_t res;
    res = '0;
    case (kind)
      bde_pkg::REQ_PUSH_FRONT: begin
        if (held < DEPTH) begin
          front_slot = slot_at(DEPTH - 1);
          model_store[front_slot] = value;
          held = held + 1'b1;
          res.ok = 1'b1;
        end
      end
      bde_pkg::REQ_PUSH_BACK: begin
        if (held < DEPTH) begin
          model_store[slot_at(int'(held))] = value;
          held = held + 1'b1;
          res.ok = 1'b1;
        end
      end
      bde_pkg::REQ_POP_FRONT: begin
        if (held > 0) begin
          res.data = model_store[front_slot];
          front_slot = slot_at(1);
          held = held - 1'b1;
          res.ok = 1'b1;
        end
      end
      bde_pkg::REQ_POP_BACK: begin
        if (held > 0) begin
          res.data = model_store[slot_at(int'(held) - 1)];
          held = held - 1'b1;
          res.ok = 1'b1;
        end
      end
      bde_pkg::REQ_READ: begin
        if (pos < held) begin
          res.data = model_store[slot_at(int'(pos))];
          res.ok = 1'b1;
        end
      end
      default: ;  // unknown kinds leave the deque alone
    endcase
    res.level = held;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    deque_result_t want;
    logic [BYTE_W-1:0]  got_data;
    logic [COUNT_W-1:0] got_level;
    if (!rst_ni) begin
      front_slot   = '0;
      held         = '0;
      fail_count_o = 0;
      pending_o    = 0;
      expected_q.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_q.push_back(apply_request(s_axis_tuser, s_axis_tdata[BYTE_W-1:0],
                                           s_axis_tdata[BYTE_W +: POS_W]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got_data  = m_axis_tdata[BYTE_W-1:0];
        got_level = m_axis_tdata[BYTE_W +: COUNT_W];
        if (expected_q.size() == 0) begin
          $display("%0t: result word with nothing expected: data %0h ok %0b level %0d",
                   $time, got_data, m_axis_tuser, got_level);
          fail_count_o++;
        end else begin
          want = expected_q.pop_front();
          if (got_data !== want.data) begin
            $display("%0t: data_out expected %0h, got %0h", $time, want.data, got_data);
            fail_count_o++;
          end
          if (m_axis_tuser !== want.ok) begin
            $display("%0t: success expected %0b, got %0b", $time, want.ok, m_axis_tuser);
            fail_count_o++;
          end
          if (got_level !== want.level) begin
            $display("%0t: fill_level expected %0d, got %0d", $time, want.level, got_level);
            fail_count_o++;
          end
        end
      end
      pending_o = expected_q.size();
    end
  end

endmodule

>>> bench/byte_deque_engine_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_deque_engine_core_test
// Drives request words into the byte deque: a short directed run over empty,
// wrap-around and out-of-range cases, a long mixed random run at low fill,
// then a drain back to empty with refused pops at the end. Both channels
// idle at random; once the result side holds off long enough to back up the
// request side. The checker beside the block does the scoring.
// ----------------------------------------------------------------------------
module byte_deque_engine_core_test;

  localparam int unsigned DEPTH     = bde_pkg::BDE_DEPTH;
  localparam int unsigned COUNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned REQ_W     = bde_pkg::REQ_W;
  localparam int unsigned BYTE_W    = bde_pkg::BYTE_W;
  localparam int unsigned POS_W     = bde_pkg::POS_W;
  localparam int unsigned IN_DATA_W = bde_pkg::IN_DATA_W;
  localparam int unsigned OUT_W     = ((BYTE_W + COUNT_W + 7) / 8) * 8;
  localparam int          RANDOM_WORDS = 640;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata  = '0;  // push_byte, position
  logic [REQ_W-1:0]     s_axis_tuser  = '0;  // req_type
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OUT_W-1:0]     m_axis_tdata;        // data_out, fill_level
  logic                 m_axis_tuser;        // success

  int fail_count;
  int pending;
  int words_sent  = 0;
  int fill        = 0;
  bit quiet_spell = 1'b0;
  bit stall_done  = 1'b0;

  always #1 clk_i = ~clk_i;

  byte_deque_engine_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  byte_deque_engine_core_checker #(.OUT_W(OUT_W)) i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // Mostly no gap, some short ones, a few long ones; none during a quiet spell.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (quiet_spell || r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  task automatic send_word(input logic [REQ_W-1:0]  kind,
                           input logic [BYTE_W-1:0] value,
                           input logic [POS_W-1:0]  pos);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_DATA_W'({pos, value});
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;
    if (words_sent % 40 == 0) quiet_spell = ($urandom_range(3) == 0);
    // track the fill level only to steer read positions and the drain
    case (kind)
      bde_pkg::REQ_PUSH_FRONT, bde_pkg::REQ_PUSH_BACK: if (fill < DEPTH) fill++;
      bde_pkg::REQ_POP_FRONT, bde_pkg::REQ_POP_BACK:   if (fill > 0) fill--;
      default: ;
    endcase
  endtask

  task automatic random_word(input int push_pct, input int pop_pct);
    int r;
    logic [REQ_W-1:0] kind;
    logic [POS_W-1:0] pos;
    r   = $urandom_range(99);
    pos = POS_W'($urandom);
    if (r < push_pct) begin
      kind = $urandom_range(1) ? bde_pkg::REQ_PUSH_BACK : bde_pkg::REQ_PUSH_FRONT;
    end else if (r < push_pct + pop_pct) begin
      kind = $urandom_range(1) ? bde_pkg::REQ_POP_BACK : bde_pkg::REQ_POP_FRONT;
    end else if (r < 97) begin
      kind = bde_pkg::REQ_READ;
      if (fill > 0 && $urandom_range(3) != 0) pos = POS_W'($urandom_range(fill - 1));
    end else begin
      kind = REQ_W'($urandom_range(2 ** REQ_W - 1, int'(bde_pkg::REQ_READ) + 1));
    end
    send_word(kind, BYTE_W'($urandom), pos);
  endtask

  // Result side: random ready pattern, plus one long hold-off that backs up
  // the request side.
  initial begin
    int gap;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (!stall_done && words_sent >= 120) begin
        stall_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(12, 1)) @(posedge clk_i);
      gap = pick_gap();
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  initial begin
    int waited;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty deque: refused pops and read, then unknown kinds
    send_word(bde_pkg::REQ_POP_FRONT, 8'hFF, '0);
    send_word(bde_pkg::REQ_POP_BACK, 8'hFF, '0);
    send_word(bde_pkg::REQ_READ, 8'h00, '0);
    for (int k = int'(bde_pkg::REQ_READ) + 1; k < 2 ** REQ_W; k++) begin
      send_word(REQ_W'(k), 8'hFF, '1);
    end
    // fill both ends; the first front push wraps the head below slot zero
    send_word(bde_pkg::REQ_PUSH_BACK, 8'h00, '1);
    send_word(bde_pkg::REQ_PUSH_BACK, 8'hFF, '0);
    send_word(bde_pkg::REQ_PUSH_FRONT, 8'hA5, '1);
    send_word(bde_pkg::REQ_PUSH_FRONT, 8'h5A, '0);
    send_word(bde_pkg::REQ_READ, 8'h00, POS_W'(0));
    send_word(bde_pkg::REQ_READ, 8'h00, POS_W'(3));
    send_word(bde_pkg::REQ_READ, 8'h00, POS_W'(4));
    send_word(bde_pkg::REQ_READ, 8'h00, '1);
    send_word(bde_pkg::REQ_POP_FRONT, 8'h00, '0);
    send_word(bde_pkg::REQ_POP_BACK, 8'h00, '0);
    send_word(bde_pkg::REQ_READ, 8'h00, POS_W'(1));
    send_word(bde_pkg::REQ_POP_BACK, 8'h00, '0);
    send_word(bde_pkg::REQ_POP_FRONT, 8'h00, '0);
    send_word(bde_pkg::REQ_POP_FRONT, 8'h00, '0);

    // mixed traffic at low fill
    repeat (RANDOM_WORDS) random_word(40, 30);

    // reads at the edges, then drain to empty and refuse pops
    send_word(bde_pkg::REQ_READ, 8'h00, '1);
    send_word(bde_pkg::REQ_READ, 8'h00, '0);
    repeat (4) random_word(0, 0);
    while (fill > 0) random_word(10, 80);
    repeat (4) random_word(0, 100);

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    waited = 0;
    while (pending != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("byte_deque_engine_core regression: pass");
    end else begin
      $display("byte_deque_engine_core regression: fail");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("byte_deque_engine_core regression: fail");
    $finish;
  end

endmodule

>>> filelist.f
hdl/bde_pkg.sv
hdl/bde_ram.sv
hdl/bde_ctrl.sv
hdl/bde_dpath.sv
hdl/byte_deque_engine_core.sv
bench/byte_deque_engine_core_checker.sv
bench/byte_deque_engine_core_test.sv
